// ===== rtl/postfix_stack_evaluator_top_defines.svh =====
// assertion macros shared by the postfix evaluator rtl
`ifndef POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pse_pkg.sv =====
// shared types, character codes and command/status structs of the postfix evaluator
package pse_pkg;

    localparam int DATA_W     = 32;
    localparam int SYM_W      = 8;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = 6;

    // ascii codes
    localparam logic [SYM_W-1:0] CH_0     = 8'h30;
    localparam logic [SYM_W-1:0] CH_9     = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CL_OTHER,
        CL_DIGIT,
        CL_OPER
    } t_sym_class;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic {
        RD_TOP,
        RD_SECOND
    } t_rd_sel;

    typedef enum logic {
        RES_ALU,
        RES_DIV
    } t_res_sel;

    // controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     push;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     latch_rhs;
        logic     latch_lhs;
        logic     div_start;
        logic     load_result;
        t_res_sel result_sel;
        logic     write_result;
        logic     flag_en;
        t_status  flag_code;
        logic     load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_sym_class sym_class;
        logic       is_div;
        logic       last;
        logic       count_lt2;
        logic       count_full;
        logic       rhs_zero;
        logic       div_done;
        logic       out_busy;
    } t_sts;

    function automatic t_sym_class classify_sym(input logic [SYM_W-1:0] sym);
        t_sym_class cls;
        cls = CL_OTHER;
        if (sym >= CH_0 && sym <= CH_9) begin
            cls = CL_DIGIT;
        end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR
                     || sym == CH_SLASH) begin
            cls = CL_OPER;
        end
        return cls;
    endfunction

    function automatic t_op decode_op(input logic [SYM_W-1:0] sym);
        t_op op;
        case (sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/pse_div.sv =====
// radix-2 restoring divider, signed 32-bit with truncation toward zero
module pse_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pse_pkg::DATA_W-1:0] i_dividend,
    input  logic [pse_pkg::DATA_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [pse_pkg::DATA_W-1:0] o_quotient
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_trial;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

    // one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= magnitude(i_dividend);
            r_den <= magnitude(i_divisor);
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!w_trial[DATA_W]) begin
                r_rem <= w_trial[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + DATA_W'(1)) : r_quo;

endmodule

// ===== rtl/pse_dp.sv =====
// datapath: operand stack memory, operand and result registers, alu, divider, output beat
module pse_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pse_pkg::SYM_W-1:0]     i_symbol,
    input  logic                          i_last,
    input  pse_pkg::t_cmd                 i_cmd,
    output pse_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [pse_pkg::OUT_DATA_W-1:0] o_out_data
);
    import pse_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [SYM_W-1:0]  r_sym;
    logic              r_last;
    logic [CW-1:0]     r_count;
    t_status           r_err;
    logic [DATA_W-1:0] r_rdata;
    logic [DATA_W-1:0] r_lhs;
    logic [DATA_W-1:0] r_rhs;
    logic [DATA_W-1:0] r_result;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_out_status;

    logic [CW-1:0]     w_cnt_m1;
    logic [CW-1:0]     w_cnt_m2;
    logic [AW-1:0]     w_rd_addr;
    logic [AW-1:0]     w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_wr_en;
    logic [DATA_W-1:0] w_alu;
    logic              w_div_done;
    logic [DATA_W-1:0] w_div_q;
    t_op               w_op;

    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_op     = decode_op(r_sym);

    // stack memory ports
    assign w_rd_addr = (i_cmd.rd_sel == RD_SECOND) ? w_cnt_m2[AW-1:0] : w_cnt_m1[AW-1:0];
    assign w_wr_en   = i_cmd.push | i_cmd.write_result;
    assign w_wr_addr = i_cmd.push ? r_count[AW-1:0] : w_cnt_m2[AW-1:0];
    assign w_wr_data = i_cmd.push ? DATA_W'(r_sym - CH_0) : r_result;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // alu for add, subtract and multiply; zero stands for a division by zero
    always_comb begin
        case (w_op)
            OP_ADD:  w_alu = r_lhs + r_rhs;
            OP_SUB:  w_alu = r_lhs - r_rhs;
            OP_MUL:  w_alu = r_lhs * r_rhs;
            default: w_alu = '0;
        endcase
    end

    pse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_lhs),
        .i_divisor  (r_rhs),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (i_cmd.latch_rhs) begin
            r_rhs <= r_rdata;
        end
        if (i_cmd.latch_lhs) begin
            r_lhs <= r_rdata;
        end
        if (i_cmd.load_result) begin
            r_result <= (i_cmd.result_sel == RES_DIV) ? w_div_q : w_alu;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= (r_count == '0) ? '0 : r_rdata;
            r_out_status <= r_err;
        end
    end

    // stack count, sticky error and output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_count <= '0;
            end else if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.write_result) begin
                r_count <= w_cnt_m1;
            end

            if (i_cmd.load_out) begin
                r_err <= ST_OK;
            end else if (i_cmd.flag_en && r_err == ST_OK) begin
                r_err <= i_cmd.flag_code;
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.sym_class  = classify_sym(r_sym);
        o_sts.is_div     = (w_op == OP_DIV);
        o_sts.last       = r_last;
        o_sts.count_lt2  = (r_count < CW'(2));
        o_sts.count_full = (r_count == CW'(STACK_DEPTH));
        o_sts.rhs_zero   = (r_rhs == '0);
        o_sts.div_done   = w_div_done;
        o_sts.out_busy   = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{OUT_PAD_W{1'b0}}, r_out_status, r_out_value};

endmodule

// ===== rtl/pse_ctrl.sv =====
// controller: sequences each character through dispatch and, for operators, read, execute and write steps
module pse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pse_pkg::t_sts  i_sts,
    output pse_pkg::t_cmd  o_cmd
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_LHS,
        S_LATCH_LHS,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_end_last;
    // first cycle of finish: top-of-stack read for the result beat
    // (the memory write of the last step has landed by then)
    logic   r_fin_rd;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        w_end_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.sym_class)
                    CL_DIGIT: begin
                        if (i_sts.count_full) begin
                            o_cmd.flag_en   = 1'b1;
                            o_cmd.flag_code = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                        w_end_last = 1'b1;
                    end
                    CL_OPER: begin
                        if (i_sts.count_lt2) begin
                            o_cmd.flag_en   = 1'b1;
                            o_cmd.flag_code = ST_UNDERFLOW;
                            w_end_last      = 1'b1;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_TOP;
                            n_state      = S_RD_LHS;
                        end
                    end
                    default: begin
                        w_end_last = 1'b1;
                    end
                endcase
            end
            S_RD_LHS: begin
                o_cmd.latch_rhs = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RD_SECOND;
                n_state         = S_LATCH_LHS;
            end
            S_LATCH_LHS: begin
                o_cmd.latch_lhs = 1'b1;
                n_state         = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.is_div && !i_sts.rhs_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.load_result = 1'b1;
                    o_cmd.result_sel  = RES_ALU;
                    if (i_sts.is_div) begin
                        o_cmd.flag_en   = 1'b1;
                        o_cmd.flag_code = ST_DIVZERO;
                    end
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.load_result = 1'b1;
                    o_cmd.result_sel  = RES_DIV;
                    n_state           = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_result = 1'b1;
                w_end_last         = 1'b1;
            end
            S_FINISH: begin
                if (r_fin_rd) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_TOP;
                end else if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // close of a character: finish the expression on its last beat
        if (w_end_last) begin
            if (i_sts.last) begin
                n_state = S_FINISH;
            end else begin
                n_state = S_IDLE;
            end
        end
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_fin_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= (n_state == S_IDLE);
            r_fin_rd <= (n_state == S_FINISH) && (r_state != S_FINISH);
        end
    end

    assign o_in_ready = r_ready;

endmodule

// ===== rtl/postfix_stack_evaluator_top.sv =====
// postfix evaluator: evaluates single-digit postfix expressions arriving one character per beat
// The block takes one ASCII character per input beat (tdata = symbol, tlast = end of
// expression). Digits push their value, + - * / pop two values and push the wrapped 32-bit
// result of second-popped op first-popped, with division truncating toward zero and a
// division by zero giving 0. On the beat marked tlast one output beat carries the stack top
// (0 when empty) and the first error of the expression (0 ok, 1 underflow, 2 overflow,
// 3 divide by zero), after which stack and error are cleared. A character is finished before
// the next beat is accepted: digits, ignored characters and operators that underflow end in
// dispatch; add, subtract and multiply read top and second, execute and write back; division
// also runs the 32-step radix-2 divider. A tlast beat adds a registered top-of-stack read of
// the stack memory, plus any wait while an earlier output beat is still held by the sink. Once
// loaded, an output beat waits in its register while the next characters are taken.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,   // end_of_expr
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] value, [33:32] status, [39:34] zero
);
    import pse_pkg::*;

    `include "postfix_stack_evaluator_top_defines.svh"

    t_cmd w_cmd;
    t_sts w_sts;

    pse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pse_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_symbol    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // checks
    `PSE_ASSERT_NEXT(a_one_char_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a character is in work")
    `PSE_ASSERT_NOW(a_push_only_with_room, w_cmd.push, !w_sts.count_full, "push on a full stack")
    `PSE_ASSERT_NOW(a_div_nonzero, w_cmd.div_start, !w_sts.rhs_zero, "divider started with a zero divisor")
    `PSE_ASSERT_NEXT(a_load_gives_beat, w_cmd.load_out, m_axis_tvalid, "result beat not shown after load")

endmodule
